// File: sv/dfsdt_pkg.sv
// Shared types and constants for the depth-first search discovery-time engine.
// No dependencies; used by dfsdt_edge_store and dfs_discovery_time_engine.
`default_nettype none

package dfsdt_pkg;

  localparam int VERTEX_W = 7;
  localparam int DISC_W   = 7;
  localparam int TIME_W   = 8;
  localparam int DATA_W   = 16;

  localparam logic [DISC_W-1:0]   DISC_MAX     = 7'd127;
  localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic [VERTEX_W-1:0] b;
    logic [VERTEX_W-1:0] a;
  } edge_t;

  typedef struct packed {
    logic add;
    logic clear;
    logic rd_en;
  } edge_cmd_t;

endpackage

`default_nettype wire

// File: sv/dfsdt_edge_store.sv
// Edge store: appends endpoint pairs in insertion order, keeps the fill count
// and the overflow flag, and serves one registered read a cycle. Uses dfsdt_pkg.
`default_nettype none

module dfsdt_edge_store #(
  parameter int MAX_EDGES = 256,
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECNT_W = $clog2(MAX_EDGES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dfsdt_pkg::edge_cmd_t cmd,
  input  dfsdt_pkg::edge_t     wr_edge,
  input  logic [EIDX_W-1:0]    rd_addr,
  output dfsdt_pkg::edge_t     rd_edge,
  output logic [ECNT_W-1:0]    edge_total,
  output logic                 overflow
);

  dfsdt_pkg::edge_t mem [MAX_EDGES];

  logic has_room;

  assign has_room = edge_total < ECNT_W'(MAX_EDGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end else if (cmd.clear) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end else if (cmd.add) begin
      if (has_room) begin
        edge_total <= edge_total + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && has_room) begin
      mem[edge_total[EIDX_W-1:0]] <= wr_edge;
    end
    if (cmd.rd_en) begin
      rd_edge <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/dfs_discovery_time_engine.sv
// Depth-first search discovery-time engine. An add word (tuser low) stores one
// undirected edge; edges past MAX_EDGES are dropped and flagged on the next run. A
// run word (tuser high) walks vertices 1..vertex_count (clamped to 1..MAX_VERTICES)
// as roots in index order, follows neighbours in insertion order with a stack held in
// memory, then streams one result per vertex and clears the edge store. The run is
// paced by the single read port of the edge store: each edge examined takes an address
// step, then a test of the registered data; each vertex reached takes its root step or
// the pop of its parent frame, and a step that finishes it; each root candidate takes a
// step; and each result takes a read step and a write step, the write waiting while
// the result output is stalled.
// No new word is taken while a run is in progress. Uses dfsdt_pkg, dfsdt_edge_store.
`default_nettype none

module dfs_discovery_time_engine #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: vertex_count
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfsdt_pkg::VERTEX_W-1:0] cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dfsdt_pkg::DATA_W-1:0]   s_tdata,   // vertex_a [6:0], vertex_b [13:7]
  input  logic                           s_tuser,   // opcode
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dfsdt_pkg::DATA_W-1:0]   m_tdata,   // vertex_id [6:0], discovery_time [13:7]
  output logic                           m_tlast,
  output logic                           m_tuser    // edges_dropped
);

  localparam int VW     = dfsdt_pkg::VERTEX_W;
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int VIDX_W = $clog2(MAX_VERTICES + 1);
  localparam int SIDX_W = $clog2(MAX_VERTICES);
  localparam int DEP_W  = $clog2(MAX_VERTICES + 2);
  localparam int FRM_W  = VW + ECNT_W;
  localparam int PAD_W  = dfsdt_pkg::DATA_W - VW - dfsdt_pkg::DISC_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ROOT    = 7'b0000010,
    S_FETCH   = 7'b0000100,
    S_TEST    = 7'b0001000,
    S_POP     = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [VW-1:0]                      vertex_count;
  logic [VW-1:0]                      n_eff;
  logic [MAX_VERTICES:0]              visited;
  logic [dfsdt_pkg::TIME_W-1:0]       time_count;
  logic [dfsdt_pkg::TIME_W-1:0]       time_inc;
  logic [VW-1:0]                      root;
  logic [VW-1:0]                      cur_v;
  logic [ECNT_W-1:0]                  cur_e;
  logic [ECNT_W-1:0]                  cur_e_inc;
  logic [DEP_W-1:0]                   depth;
  logic [DEP_W-1:0]                   depth_m1;
  logic [DEP_W-1:0]                   depth_m2;
  logic [VW-1:0]                      emit_v;

  // discovery times and walk stack
  logic [dfsdt_pkg::DISC_W-1:0]       disc_mem [MAX_VERTICES + 1];
  logic [dfsdt_pkg::DISC_W-1:0]       disc_rd;
  logic                               disc_we;
  logic [VIDX_W-1:0]                  disc_wa;
  logic [dfsdt_pkg::DISC_W-1:0]       disc_wd;
  logic [FRM_W-1:0]                   stk_mem [MAX_VERTICES];
  logic [FRM_W-1:0]                   stk_rd;

  dfsdt_pkg::edge_cmd_t               ecmd;
  dfsdt_pkg::edge_t                   e_wr;
  dfsdt_pkg::edge_t                   e_rd;
  logic [ECNT_W-1:0]                  edge_total;
  logic                               overflow;

  logic                               in_acc;
  logic                               out_free;
  logic                               in_range;
  logic                               hit_a;
  logic                               hit_b;
  logic                               have;
  logic [VW-1:0]                      found;
  logic                               root_new;
  logic                               scan_end;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign n_eff = (vertex_count == '0) ? VW'(1) :
                 (vertex_count > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vertex_count;

  assign e_wr.a = s_tdata[VW-1:0];
  assign e_wr.b = s_tdata[2*VW-1:VW];

  assign time_inc  = time_count + 1'b1;
  assign cur_e_inc = cur_e + 1'b1;
  assign depth_m1  = depth - 1'b1;
  assign depth_m2  = depth - 2'd2;
  assign scan_end  = cur_e >= edge_total;

  // neighbour test on the fetched edge; skip edges with an endpoint beyond the count
  assign in_range = (e_rd.a <= n_eff) && (e_rd.b <= n_eff);
  assign hit_b    = in_range && (e_rd.a == cur_v) && !visited[e_rd.b[VIDX_W-1:0]];
  assign hit_a    = in_range && (e_rd.b == cur_v) && !visited[e_rd.a[VIDX_W-1:0]];
  assign have     = hit_a || hit_b;
  assign found    = hit_b ? e_rd.b : e_rd.a;
  assign root_new = (root <= n_eff) && !visited[root[VIDX_W-1:0]];

  always_comb begin
    ecmd.add   = in_acc && (s_tuser == dfsdt_pkg::OP_ADD);
    ecmd.clear = (state == S_EMIT_WR) && out_free && (emit_v == n_eff);
    ecmd.rd_en = (state == S_FETCH) && !scan_end;
  end

  dfsdt_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edges (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ecmd),
    .wr_edge    (e_wr),
    .rd_addr    (cur_e[EIDX_W-1:0]),
    .rd_edge    (e_rd),
    .edge_total (edge_total),
    .overflow   (overflow)
  );

  always_comb begin
    disc_we = 1'b0;
    disc_wa = root[VIDX_W-1:0];
    disc_wd = (time_inc > dfsdt_pkg::TIME_W'(dfsdt_pkg::DISC_MAX)) ?
              dfsdt_pkg::DISC_MAX : time_inc[dfsdt_pkg::DISC_W-1:0];
    if (state == S_ROOT && root_new) begin
      disc_we = 1'b1;
    end else if (state == S_TEST && have) begin
      disc_we = 1'b1;
      disc_wa = found[VIDX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && s_tuser == dfsdt_pkg::OP_RUN) state_next = S_ROOT;
      end
      S_ROOT: begin
        if (root > n_eff) state_next = S_EMIT_RD;
        else if (root_new) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (!scan_end) state_next = S_TEST;
        else if (depth == DEP_W'(1)) state_next = S_ROOT;
        else state_next = S_POP;
      end
      S_TEST:    state_next = S_FETCH;
      S_POP:     state_next = S_FETCH;
      S_EMIT_RD: state_next = S_EMIT_WR;
      S_EMIT_WR: begin
        if (out_free) state_next = (emit_v == n_eff) ? S_IDLE : S_EMIT_RD;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= dfsdt_pkg::VCOUNT_RESET;
      visited      <= '0;
      time_count   <= '1;
      depth        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
      // load a new word when the output is free, otherwise drop it once taken
      if (state == S_EMIT_WR && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && s_tuser == dfsdt_pkg::OP_RUN) begin
            visited    <= '0;
            time_count <= '1;
            depth      <= '0;
          end
        end
        S_ROOT: begin
          if (root_new) begin
            visited[root[VIDX_W-1:0]] <= 1'b1;
            time_count <= time_inc;
            depth      <= DEP_W'(1);
          end
        end
        S_FETCH: begin
          // nothing left to scan: finish this vertex and drop its frame
          if (scan_end) begin
            time_count <= time_inc;
            depth      <= depth_m1;
          end
        end
        S_TEST: begin
          if (have) begin
            visited[found[VIDX_W-1:0]] <= 1'b1;
            time_count <= time_inc;
            depth      <= depth + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        root   <= VW'(1);
        emit_v <= VW'(1);
      end
      S_ROOT: begin
        if (root_new) begin
          cur_v <= root;
          cur_e <= '0;
        end else if (root <= n_eff) begin
          root <= root + 1'b1;
        end
      end
      S_TEST: begin
        if (have) begin
          cur_v <= found;
          cur_e <= '0;
        end else begin
          cur_e <= cur_e_inc;
        end
      end
      S_POP: begin
        cur_v <= stk_rd[FRM_W-1:ECNT_W];
        cur_e <= stk_rd[ECNT_W-1:0];
      end
      S_EMIT_WR: begin
        if (out_free) begin
          m_tdata <= {{PAD_W{1'b0}}, disc_rd, emit_v};
          m_tlast <= (emit_v == n_eff);
          m_tuser <= overflow;
          emit_v  <= emit_v + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    if (state == S_EMIT_RD) disc_rd <= disc_mem[emit_v[VIDX_W-1:0]];
  end

  // frames below the top live here; push at depth-1, pop reads depth-2
  always_ff @(posedge clk) begin
    if (state == S_TEST && have) stk_mem[depth_m1[SIDX_W-1:0]] <= {cur_v, cur_e_inc};
    if (state == S_FETCH && scan_end && depth != DEP_W'(1)) begin
      stk_rd <= stk_mem[depth_m2[SIDX_W-1:0]];
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(MAX_VERTICES + 1))
    else $error("walk stack deeper than the vertex set");

  a_root_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> (depth == '0))
    else $error("root scan entered with frames still on the stack");

  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && scan_end && depth == DEP_W'(1)) |=> (state == S_ROOT && depth == '0))
    else $error("finishing the root did not return to the root scan");

  a_push_white: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST && have) |=> visited[$past(found[VIDX_W-1:0])])
    else $error("discovered vertex not marked visited");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD) |-> (emit_v >= VW'(1) && emit_v <= n_eff))
    else $error("result vertex outside 1..vertex_count");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking bench for dfs_discovery_time_engine: loads random and directed graphs,
// predicts every discovery time with its own depth-first walk, and checks each result word.
// Depends on dfsdt_pkg and the engine RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTEX_W    = dfsdt_pkg::VERTEX_W;
  localparam int DISC_W      = dfsdt_pkg::DISC_W;
  localparam int DATA_W      = dfsdt_pkg::DATA_W;
  localparam int MAX_V       = 64;
  localparam int MAX_E       = 256;
  localparam int SETTLE      = 600;
  localparam int HOLD_OFF    = 5000;
  localparam int STALL_LIMIT = 200000;
  localparam int PHASE_WORDS = 8;

  typedef struct {
    logic [VERTEX_W-1:0] vertex_id;
    logic [DISC_W-1:0]   disc_time;
    logic                last;
    logic                dropped;
  } disc_result_t;

  class disc_time_scoreboard;
    typedef enum logic [1:0] {UNSEEN, OPEN, CLOSED} colour_t;

    logic [VERTEX_W-1:0] edge_a [MAX_E];
    logic [VERTEX_W-1:0] edge_b [MAX_E];
    int                  edge_total;
    bit                  overflow;
    logic [VERTEX_W-1:0] vertex_count;
    colour_t             colour [0:MAX_V];
    logic [DISC_W-1:0]   disc_at [0:MAX_V];
    int                  stack_vertex [0:MAX_V+1];
    int                  stack_next [0:MAX_V+1];
    int                  depth;
    int                  clock_step;
    disc_result_t        awaited_q [$];
    int                  errors;

    function new();
      vertex_count = dfsdt_pkg::VCOUNT_RESET;
      edge_total   = 0;
      overflow     = 0;
      errors       = 0;
    endfunction

    function void set_vertex_count(logic [VERTEX_W-1:0] value);
      vertex_count = value;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void discover(int v);
      colour[v] = OPEN;
      clock_step++;
      disc_at[v] = (clock_step > 127) ? dfsdt_pkg::DISC_MAX : DISC_W'(clock_step);
      stack_vertex[depth] = v;
      stack_next[depth]   = 0;
      depth++;
    endfunction

    // Walk the stored graph and queue one discovery time per vertex.
    function void walk_graph();
      int n, v, u, top, ea, eb;
      bit have;
      disc_result_t r;
      n = vertex_count;
      if (n < 1) n = 1;
      if (n > MAX_V) n = MAX_V;
      foreach (colour[i]) colour[i] = UNSEEN;
      depth      = 0;
      clock_step = -1;
      for (int root = 1; root <= n; root++) begin
        if (colour[root] == UNSEEN) begin
          discover(root);
          while (depth > 0) begin
            top  = depth - 1;
            v    = stack_vertex[top];
            have = 0;
            while (stack_next[top] < edge_total && !have) begin
              ea = edge_a[stack_next[top]];
              eb = edge_b[stack_next[top]];
              stack_next[top]++;
              // edges touching a vertex beyond n stay stored but play no part
              if (ea <= n && eb <= n) begin
                if (ea == v && colour[eb] == UNSEEN) begin
                  u    = eb;
                  have = 1;
                end else if (eb == v && colour[ea] == UNSEEN) begin
                  u    = ea;
                  have = 1;
                end
              end
            end
            if (have) begin
              discover(u);
            end else begin
              colour[v] = CLOSED;
              clock_step++;
              depth--;
            end
          end
        end
      end
      for (int k = 1; k <= n; k++) begin
        r.vertex_id = VERTEX_W'(k);
        r.disc_time = disc_at[k];
        r.last      = (k == n);
        r.dropped   = overflow;
        awaited_q.insert(awaited_q.size(), r);
      end
      edge_total = 0;
      overflow   = 0;
    endfunction

    function void note_word(logic op, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
      if (op == dfsdt_pkg::OP_RUN) begin
        walk_graph();
      end else if (edge_total < MAX_E) begin
        edge_a[edge_total] = a;
        edge_b[edge_total] = b;
        edge_total++;
      end else begin
        overflow = 1;
      end
    endfunction

    function void check_result(logic [VERTEX_W-1:0] vid, logic [DISC_W-1:0] dt,
                               logic last, logic dropped);
      disc_result_t e;
      if (awaited_q.size() == 0) begin
        $display("%t unexpected result: vertex_id=%0d discovery_time=%0d last=%0b dropped=%0b",
                 $time, vid, dt, last, dropped);
        errors++;
        return;
      end
      e = awaited_q.pop_front();
      if (vid !== e.vertex_id) begin
        $display("%t vertex_id mismatch: expected %0d actual %0d", $time, e.vertex_id, vid);
        errors++;
      end
      if (dt !== e.disc_time) begin
        $display("%t discovery_time mismatch (vertex %0d): expected %0d actual %0d",
                 $time, e.vertex_id, e.disc_time, dt);
        errors++;
      end
      if (last !== e.last) begin
        $display("%t last mismatch (vertex %0d): expected %0b actual %0b",
                 $time, e.vertex_id, e.last, last);
        errors++;
      end
      if (dropped !== e.dropped) begin
        $display("%t edges_dropped mismatch (vertex %0d): expected %0b actual %0b",
                 $time, e.vertex_id, e.dropped, dropped);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [VERTEX_W-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  disc_time_scoreboard sb = new();
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_request   = 0;
  int                  quiet_cycles   = 0;
  int                  words_sent     = 0;
  int                  cur_count      = 64;

  always #4 clk = ~clk;

  dfs_discovery_time_engine #(
    .MAX_VERTICES(MAX_V),
    .MAX_EDGES   (MAX_E)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[6:0], m_tdata[13:7], m_tlast, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_request = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic op, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= DATA_W'({b, a});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(op, a, b);
    words_sent++;
  endtask

  // wait for every result, then let the engine finish its clear-down
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VERTEX_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_vertex_count(value);
    cfg_valid <= 1'b0;
    cur_count = (value < 1) ? 1 : (value > MAX_V) ? MAX_V : value;
    @(posedge clk);
  endtask

  function automatic logic [VERTEX_W-1:0] pick_vertex();
    int r;
    r = $urandom_range(99);
    if (r < 85) return VERTEX_W'($urandom_range(cur_count, 0));
    if (r < 93) return VERTEX_W'($urandom_range(127, 0));
    return VERTEX_W'(cur_count);
  endfunction

  task automatic send_run();
    send_word(dfsdt_pkg::OP_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom));
  endtask

  // one graph: mostly random edges, sometimes a chain, sometimes nothing at all
  task automatic send_graph();
    int k, shape;
    logic [VERTEX_W-1:0] a, b;
    shape = $urandom_range(9);
    k     = (shape == 0) ? 0 : $urandom_range(24, 1);
    for (int i = 0; i < k; i++) begin
      if (shape == 1) begin
        a = VERTEX_W'(i % (cur_count + 1));
        b = VERTEX_W'((i + 1) % (cur_count + 1));
      end else begin
        a = pick_vertex();
        b = ($urandom_range(19) == 0) ? a : pick_vertex();
      end
      send_word(dfsdt_pkg::OP_ADD, a, b);
    end
    send_run();
  endtask

  task automatic set_random_count();
    logic [VERTEX_W-1:0] pick [9] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127, 7'd9};
    if ($urandom_range(9) < 4)
      write_vertex_count(VERTEX_W'($urandom_range(12, 2)));
    else if ($urandom_range(1) == 0)
      write_vertex_count(pick[$urandom_range(8)]);
    else
      write_vertex_count(VERTEX_W'($urandom));
  endtask

  initial begin
    int idle_pct [4]  = '{0, 78, 0, 6};
    int stall_pct [4] = '{0, 0, 78, 6};
    int phase_end;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-size graph: vertex zero hanging off vertex one pushes vertex 64 past time 127
    write_vertex_count(7'd127);
    send_word(dfsdt_pkg::OP_ADD, 7'd1, 7'd0);
    send_word(dfsdt_pkg::OP_ADD, 7'd3, 7'd3);
    send_word(dfsdt_pkg::OP_ADD, 7'd127, 7'd2);
    send_word(dfsdt_pkg::OP_ADD, 7'd0, 7'd127);
    send_word(dfsdt_pkg::OP_ADD, 7'd2, 7'd3);
    send_word(dfsdt_pkg::OP_ADD, 7'd65, 7'd64);
    send_word(dfsdt_pkg::OP_ADD, 7'd64, 7'd64);
    send_word(dfsdt_pkg::OP_RUN, 7'h7f, 7'h7f);
    // a count of zero behaves as one
    write_vertex_count(7'd0);
    send_word(dfsdt_pkg::OP_ADD, 7'd0, 7'd1);
    send_word(dfsdt_pkg::OP_ADD, 7'd1, 7'd0);
    send_run();
    write_vertex_count(7'd3);
    send_word(dfsdt_pkg::OP_ADD, 7'd3, 7'd1);
    send_word(dfsdt_pkg::OP_ADD, 7'd2, 7'd0);
    send_word(dfsdt_pkg::OP_ADD, 7'd0, 7'd3);
    send_word(dfsdt_pkg::OP_ADD, 7'd4, 7'd2);
    send_run();
    send_run();
    // overfill the edge store, then check the flag clears on the following run
    write_vertex_count(7'd64);
    for (int i = 0; i < MAX_E + 3; i++)
      send_word(dfsdt_pkg::OP_ADD, VERTEX_W'($urandom_range(MAX_V, 0)),
                VERTEX_W'($urandom_range(MAX_V, 0)));
    send_run();
    send_run();
    // hold the result side off while more graphs are offered, so the input stalls
    hold_request = 1;
    send_graph();
    send_graph();

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      set_random_count();
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(4) == 0) set_random_count();
        send_graph();
      end
    end

    drain();
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/dfsdt_pkg.sv
sv/dfsdt_edge_store.sv
sv/dfs_discovery_time_engine.sv
verif/tb_top.sv
